// File: rtl/core/clt_pkg.sv
// Package for the config line tokenizer: word types, character codes,
// error codes, tokenizer state and helper functions. No dependencies.
`default_nettype none

package clt_pkg;

	// Sizing of the group depth counters and the line counter
	localparam int DEPTH_BITS = 8;
	localparam int LINE_BITS  = 16;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;

	// Character codes
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;

	// Error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd1;
	localparam logic [2:0] ERR_PAREN_UNDER = 3'd2;
	localparam logic [2:0] ERR_BRACK_UNDER = 3'd3;
	localparam logic [2:0] ERR_OPEN_GROUP  = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} clt_in_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        append;
		logic        token_done;
		logic        line_done;
		logic [2:0]  error_code;
		logic [15:0] line_number;
	} clt_out_t;

	typedef struct packed {
		logic                  in_quote;
		logic                  escape_pending;
		logic                  in_comment;
		logic                  after_cr;
		logic [DEPTH_BITS-1:0] paren_depth;
		logic [DEPTH_BITS-1:0] bracket_depth;
		logic                  token_open;
		logic                  line_has_tokens;
		logic [LINE_BITS-1:0]  line_counter;
	} clt_state_t;

	localparam clt_state_t STATE_RESET = '{
		in_quote:        1'b0,
		escape_pending:  1'b0,
		in_comment:      1'b0,
		after_cr:        1'b0,
		paren_depth:     '0,
		bracket_depth:   '0,
		token_open:      1'b0,
		line_has_tokens: 1'b0,
		line_counter:    LINE_BITS'(1)
	};

	// Clamp the line counter to the 16-bit result field
	function automatic logic [15:0] line_out(input logic [LINE_BITS-1:0] v);
		logic [LINE_BITS+15:0] w;
		w = {16'd0, v};
		if (w > (LINE_BITS+16)'(16'hFFFF)) begin
			return 16'hFFFF;
		end
		return w[15:0];
	endfunction

	function automatic logic valid_escape(input logic [7:0] c);
		return c inside {CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_RPAREN,
			CH_LBRACKET, CH_RBRACKET, CH_HASH};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/clt_core.sv
// Tokenizer state registers and the per-byte decode that updates them.
// Depends on clt_pkg.
`default_nettype none

module clt_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire clt_pkg::clt_in_t item,
	output clt_pkg::clt_out_t    result
);

	clt_pkg::clt_state_t state_q;
	clt_pkg::clt_state_t state_nxt;

	logic [7:0] c;
	logic       is_nl;
	logic       is_blank;
	logic       groups_open;
	logic       app;
	logic       flush_tok;
	logic       flush_line;
	logic       tok_done;
	logic       ln_done;
	logic       bump_line;
	logic [2:0] err;

	always_comb begin
		c           = item.text_byte;
		is_nl       = (c == clt_pkg::CH_LF) || (c == clt_pkg::CH_CR);
		is_blank    = (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB);
		groups_open = (state_q.paren_depth != '0) || (state_q.bracket_depth != '0);

		state_nxt          = state_q;
		state_nxt.after_cr = 1'b0;
		app        = 1'b0;
		flush_tok  = 1'b0;
		flush_line = 1'b0;
		bump_line  = 1'b0;
		err        = clt_pkg::ERR_NONE;
		tok_done   = 1'b0;
		ln_done    = 1'b0;

		if (state_q.after_cr && c == clt_pkg::CH_LF) begin
			// second half of CR LF: drop
		end else if (state_q.in_comment) begin
			if (is_nl) begin
				state_nxt.in_comment = 1'b0;
				state_nxt.after_cr   = (c == clt_pkg::CH_CR);
				bump_line            = 1'b1;
			end
		end else if (state_q.escape_pending) begin
			if (!clt_pkg::valid_escape(c)) begin
				err = clt_pkg::ERR_BAD_ESCAPE;
			end
			app                      = 1'b1;
			state_nxt.escape_pending = 1'b0;
		end else if (c == clt_pkg::CH_BACKSLASH) begin
			state_nxt.escape_pending = 1'b1;
		end else if (c == clt_pkg::CH_DQUOTE) begin
			state_nxt.in_quote = !state_q.in_quote;
			app                = 1'b1;
		end else if (state_q.in_quote) begin
			app = 1'b1;
		end else if (c == clt_pkg::CH_HASH) begin
			flush_tok            = 1'b1;
			flush_line           = 1'b1;
			state_nxt.in_comment = 1'b1;
		end else if (c == clt_pkg::CH_LPAREN) begin
			if (state_q.paren_depth != clt_pkg::DEPTH_MAX) begin
				state_nxt.paren_depth = state_q.paren_depth + 1'b1;
			end
			app = 1'b1;
		end else if (c == clt_pkg::CH_RPAREN) begin
			if (state_q.paren_depth == '0) begin
				err = clt_pkg::ERR_PAREN_UNDER;
			end else begin
				state_nxt.paren_depth = state_q.paren_depth - 1'b1;
			end
			app = 1'b1;
		end else if (c == clt_pkg::CH_LBRACKET) begin
			if (state_q.bracket_depth != clt_pkg::DEPTH_MAX) begin
				state_nxt.bracket_depth = state_q.bracket_depth + 1'b1;
			end
			app = 1'b1;
		end else if (c == clt_pkg::CH_RBRACKET) begin
			if (state_q.bracket_depth == '0) begin
				err = clt_pkg::ERR_BRACK_UNDER;
			end else begin
				state_nxt.bracket_depth = state_q.bracket_depth - 1'b1;
			end
			app = 1'b1;
		end else if (is_nl) begin
			if (groups_open) begin
				err = clt_pkg::ERR_OPEN_GROUP;
			end
			flush_tok          = 1'b1;
			flush_line         = 1'b1;
			bump_line          = 1'b1;
			state_nxt.after_cr = (c == clt_pkg::CH_CR);
		end else if (is_blank && !groups_open) begin
			flush_tok = 1'b1;
		end else begin
			app = 1'b1;
		end

		if (bump_line && state_q.line_counter != clt_pkg::LINE_MAX) begin
			state_nxt.line_counter = state_q.line_counter + 1'b1;
		end

		if (app) begin
			state_nxt.token_open = 1'b1;
		end
		if (item.is_last) begin
			flush_tok  = 1'b1;
			flush_line = 1'b1;
		end
		if (flush_tok && state_nxt.token_open) begin
			tok_done                  = 1'b1;
			state_nxt.token_open      = 1'b0;
			state_nxt.line_has_tokens = 1'b1;
		end
		if (flush_line && state_nxt.line_has_tokens) begin
			ln_done                   = 1'b1;
			state_nxt.line_has_tokens = 1'b0;
		end
		if (item.is_last) begin
			state_nxt = clt_pkg::STATE_RESET;
		end

		result.byte_out    = c;
		result.append      = app;
		result.token_done  = tok_done;
		result.line_done   = ln_done;
		result.error_code  = err;
		result.line_number = clt_pkg::line_out(state_q.line_counter);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clt_pkg::STATE_RESET;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/config_line_tokenizer.sv
// Config line tokenizer: one text byte in, one token/line result word out.
// A taken word sits in the input register; its result goes to dst from the
// result register. Throughput: one word per cycle, limited only by dst_stall;
// src_stall rises only when both registers are full and dst_stall is high.
// Reset (arst_n low): both registers empty, tokenizer state cleared, line 1.
// Depends on clt_pkg and clt_core.
`default_nettype none

module config_line_tokenizer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// source channel
	input  wire logic          src_valid,
	output logic               src_stall,
	input  wire clt_pkg::clt_in_t src_word,
	// destination channel
	output logic               dst_valid,
	input  wire logic          dst_stall,
	output clt_pkg::clt_out_t  dst_word
);

	// Input register
	logic              valid_s1;
	clt_pkg::clt_in_t  word_s1;

	// Result register
	logic              valid_s2;
	clt_pkg::clt_out_t word_s2;

	clt_pkg::clt_out_t result;

	logic s2_free;
	logic advance;
	logic take;

	// The result register can load when empty or when its word leaves now.
	assign s2_free   = !valid_s2 || !dst_stall;
	// Advance the held byte into the result register; the state steps with it.
	assign advance   = valid_s1 && s2_free;
	// Hold the source only when the input register cannot empty this cycle.
	assign src_stall = valid_s1 && !s2_free;
	assign take      = src_valid && !src_stall;

	assign dst_valid = valid_s2;
	assign dst_word  = word_s2;

	clt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (word_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!dst_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: load on handshake, otherwise hold
	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= src_word;
		end
		if (advance) begin
			word_s2 <= result;
		end
	end

endmodule

`default_nettype wire

// File: test/tokenizer_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the config line tokenizer: tracks quoting, comments and group depth per word.
// Depends on clt_pkg for the word types, character codes and error codes.

module tokenizer_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  logic               src_stall,
	input  clt_pkg::clt_in_t   src_word,
	input  logic               dst_valid,
	input  logic               dst_stall,
	input  clt_pkg::clt_out_t  dst_word,
	output int                 failures,
	output int                 results_due
);
	import clt_pkg::*;

	logic                  quoting;
	logic                  escaping;
	logic                  commenting;
	logic                  cr_seen;
	logic [DEPTH_BITS-1:0] parens;
	logic [DEPTH_BITS-1:0] brackets;
	logic                  tok_open;
	logic                  line_tokens;
	logic [LINE_BITS-1:0]  line_no;

	clt_out_t tokenizer_results_due[$];
	clt_out_t predicted;
	clt_out_t wanted;

	task automatic clear_tokenizer();
		quoting     = 1'b0;
		escaping    = 1'b0;
		commenting  = 1'b0;
		cr_seen     = 1'b0;
		parens      = '0;
		brackets    = '0;
		tok_open    = 1'b0;
		line_tokens = 1'b0;
		line_no     = LINE_BITS'(1);
	endtask

	task automatic advance_line();
		if (line_no != LINE_MAX) begin
			line_no = line_no + 1'b1;
		end
	endtask

	function automatic logic escapable(input logic [7:0] c);
		return c == CH_DQUOTE || c == CH_SQUOTE || c == CH_LPAREN || c == CH_RPAREN ||
			c == CH_LBRACKET || c == CH_RBRACKET || c == CH_HASH;
	endfunction

	task automatic tokenize_byte(input clt_in_t w, output clt_out_t r);
		logic [7:0]  c;
		logic [31:0] wide_line;
		logic        newline;
		logic        joins;
		logic        end_token;
		logic        end_line;
		logic        cr_before;
		c         = w.text_byte;
		newline   = (c == CH_LF) || (c == CH_CR);
		joins     = 1'b0;
		end_token = 1'b0;
		end_line  = 1'b0;
		cr_before = cr_seen;
		wide_line = 32'(line_no);
		r = '0;
		r.byte_out    = c;
		r.line_number = (wide_line > 32'h0000_FFFF) ? 16'hFFFF : wide_line[15:0];
		cr_seen = 1'b0;
		if (cr_before && c == CH_LF) begin
			// second half of a CR LF pair
		end else if (commenting) begin
			if (newline) begin
				commenting = 1'b0;
				advance_line();
				cr_seen = (c == CH_CR);
			end
		end else if (escaping) begin
			if (!escapable(c)) begin
				r.error_code = ERR_BAD_ESCAPE;
			end
			joins    = 1'b1;
			escaping = 1'b0;
		end else if (c == CH_BACKSLASH) begin
			escaping = 1'b1;
		end else if (c == CH_DQUOTE) begin
			quoting = !quoting;
			joins   = 1'b1;
		end else if (quoting) begin
			joins = 1'b1;
		end else begin
			case (c)
				CH_HASH: begin
					end_token  = 1'b1;
					end_line   = 1'b1;
					commenting = 1'b1;
				end
				CH_LPAREN: begin
					if (parens != DEPTH_MAX) begin
						parens = parens + 1'b1;
					end
					joins = 1'b1;
				end
				CH_RPAREN: begin
					if (parens == '0) begin
						r.error_code = ERR_PAREN_UNDER;
					end else begin
						parens = parens - 1'b1;
					end
					joins = 1'b1;
				end
				CH_LBRACKET: begin
					if (brackets != DEPTH_MAX) begin
						brackets = brackets + 1'b1;
					end
					joins = 1'b1;
				end
				CH_RBRACKET: begin
					if (brackets == '0) begin
						r.error_code = ERR_BRACK_UNDER;
					end else begin
						brackets = brackets - 1'b1;
					end
					joins = 1'b1;
				end
				CH_LF, CH_CR: begin
					if (parens != '0 || brackets != '0) begin
						r.error_code = ERR_OPEN_GROUP;
					end
					end_token = 1'b1;
					end_line  = 1'b1;
					advance_line();
					cr_seen = (c == CH_CR);
				end
				CH_SPACE, CH_TAB: begin
					if (parens == '0 && brackets == '0) begin
						end_token = 1'b1;
					end else begin
						joins = 1'b1;
					end
				end
				default: begin
					joins = 1'b1;
				end
			endcase
		end

		if (joins) begin
			tok_open = 1'b1;
		end
		if (w.is_last) begin
			end_token = 1'b1;
			end_line  = 1'b1;
		end
		if (end_token && tok_open) begin
			r.token_done = 1'b1;
			tok_open     = 1'b0;
			line_tokens  = 1'b1;
		end
		if (end_line && line_tokens) begin
			r.line_done = 1'b1;
			line_tokens = 1'b0;
		end
		r.append = joins;
		if (w.is_last) begin
			clear_tokenizer();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tokenizer();
			tokenizer_results_due.delete();
			results_due <= 0;
			failures    <= 0;
		end else begin
			if (src_valid && !src_stall) begin
				tokenize_byte(src_word, predicted);
				tokenizer_results_due.insert(tokenizer_results_due.size(), predicted);
			end
			if (dst_valid && !dst_stall) begin
				if (tokenizer_results_due.size() == 0) begin
					if (failures < 10) begin
						$display("%0t: unexpected word, byte %02h", $time, dst_word.byte_out);
					end
					failures <= failures + 1;
				end else begin
					wanted = tokenizer_results_due.pop_front();
					if (dst_word.byte_out !== wanted.byte_out ||
							dst_word.append !== wanted.append ||
							dst_word.token_done !== wanted.token_done ||
							dst_word.line_done !== wanted.line_done ||
							dst_word.error_code !== wanted.error_code ||
							dst_word.line_number !== wanted.line_number) begin
						if (failures < 10) begin
							$display("%0t: mismatch expected byte %02h app %b tok %b line %b err %0d ln %0d",
								$time, wanted.byte_out, wanted.append, wanted.token_done,
								wanted.line_done, wanted.error_code, wanted.line_number);
							$display("%0t:            actual byte %02h app %b tok %b line %b err %0d ln %0d",
								$time, dst_word.byte_out, dst_word.append, dst_word.token_done,
								dst_word.line_done, dst_word.error_code, dst_word.line_number);
						end
						failures <= failures + 1;
					end
				end
			end
			results_due <= tokenizer_results_due.size();
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Top of the config line tokenizer test: builds the byte stream, drives both channels and
// gives the verdict. Depends on clt_pkg, config_line_tokenizer and tokenizer_checker.

module tb;
	import clt_pkg::*;

	// Longest stretch without any word moving before the run is declared hung. The
	// longest legal stretch is the deliberate receiver hold-off below.
	localparam int HANG_LIMIT = 4000;
	localparam int HOLD_OFF   = 400;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      src_valid = 1'b0;
	clt_in_t   src_word  = '0;
	logic      dst_stall = 1'b0;
	logic      src_stall;
	logic      dst_valid;
	clt_out_t  dst_word;

	int fail_count;
	int words_due;
	int words_sent = 0;

	// Whole text, byte by byte, built before any word is offered
	clt_in_t text_stream[$];

	config_line_tokenizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word)
	);

	tokenizer_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_word    (src_word),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.dst_word    (dst_word),
		.failures    (fail_count),
		.results_due (words_due)
	);

	always #5 clk = ~clk;

	task automatic put_byte(input logic [7:0] c, input logic last);
		clt_in_t w;
		w.text_byte = c;
		w.is_last   = last;
		text_stream.insert(text_stream.size(), w);
	endtask

	// Printable character that carries no meaning to the tokenizer
	function automatic logic [7:0] word_char();
		logic [7:0] c;
		c = 8'($urandom_range(8'h21, 8'h7E));
		if (c == CH_DQUOTE || c == CH_BACKSLASH || c == CH_HASH || c == CH_LPAREN ||
				c == CH_RPAREN || c == CH_LBRACKET || c == CH_RBRACKET) begin
			c = 8'h5F;	// underscore
		end
		return c;
	endfunction

	// Byte after a backslash: mostly a legal escape, now and then an illegal one
	function automatic logic [7:0] escape_target();
		case ($urandom_range(0, 8))
			0: return CH_DQUOTE;
			1: return CH_SQUOTE;
			2: return CH_LPAREN;
			3: return CH_RPAREN;
			4: return CH_LBRACKET;
			5: return CH_RBRACKET;
			6: return CH_HASH;
			7: return CH_BACKSLASH;
			default: return word_char();
		endcase
	endfunction

	// One well-formed line: tokens, quoted strings, escapes and groups, an optional
	// comment, then LF, CR or CR LF. Occasionally the line closes the buffer.
	task automatic add_line();
		logic       last;
		logic [7:0] opener;
		logic [7:0] closer;
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 7))
				0: begin
					put_byte(CH_DQUOTE, 1'b0);
					repeat ($urandom_range(0, 6)) begin
						put_byte(($urandom_range(0, 4) == 0) ? CH_SPACE : word_char(), 1'b0);
					end
					if ($urandom_range(0, 3) == 0) begin
						put_byte(CH_BACKSLASH, 1'b0);
						put_byte(CH_DQUOTE, 1'b0);
					end
					put_byte(CH_DQUOTE, 1'b0);
				end
				1: begin
					put_byte(CH_BACKSLASH, 1'b0);
					put_byte(escape_target(), 1'b0);
				end
				2: begin
					opener = $urandom_range(0, 1) ? CH_LPAREN : CH_LBRACKET;
					closer = (opener == CH_LPAREN) ? CH_RPAREN : CH_RBRACKET;
					put_byte(opener, 1'b0);
					repeat ($urandom_range(1, 5)) begin
						case ($urandom_range(0, 3))
							0: put_byte(CH_SPACE, 1'b0);
							1: put_byte(CH_TAB, 1'b0);
							default: put_byte(word_char(), 1'b0);
						endcase
					end
					// leave the odd group open so later lines see a nonzero depth
					if ($urandom_range(0, 5) != 0) begin
						put_byte(closer, 1'b0);
					end
				end
				default: begin
					repeat ($urandom_range(1, 6)) put_byte(word_char(), 1'b0);
				end
			endcase
			repeat ($urandom_range(1, 2)) begin
				put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			put_byte(CH_HASH, 1'b0);
			repeat ($urandom_range(0, 5)) put_byte(8'($urandom), 1'b0);
		end
		last = ($urandom_range(0, 11) == 0);
		case ($urandom_range(0, 2))
			0: put_byte(CH_LF, last);
			1: put_byte(CH_CR, last);
			default: begin
				put_byte(CH_CR, 1'b0);
				put_byte(CH_LF, last);
			end
		endcase
	endtask

	// Raw bytes of any value, with the odd buffer end among them
	task automatic add_noise();
		repeat ($urandom_range(1, 10)) begin
			put_byte(8'($urandom), $urandom_range(0, 15) == 0);
		end
	endtask

	// Close the buffer so no quote, escape or comment swallows the group, then nest
	// to near or past the depth limit and unwind past zero
	task automatic add_deep_group(input logic [7:0] opener, input logic [7:0] closer);
		int n;
		n = $urandom_range(250, 270);
		put_byte(word_char(), 1'b1);
		repeat (n) put_byte(opener, 1'b0);
		put_byte(word_char(), 1'b0);
		repeat (n + 2) put_byte(closer, 1'b0);
		put_byte(CH_LF, 1'b0);
	endtask

	// Mostly well-formed lines, the rest noise, until the stream has grown by count
	task automatic add_random_text(input int count);
		int goal;
		goal = text_stream.size() + count;
		while (text_stream.size() < goal) begin
			if ($urandom_range(0, 5) == 0) begin
				add_noise();
			end else begin
				add_line();
			end
		end
	endtask

	task automatic build_text();
		// directed opening: escapes, underflows, open groups, quotes, comments, flush
		put_byte(8'h61, 1'b0);             // plain letter opens a token
		put_byte(CH_BACKSLASH, 1'b0);
		put_byte(CH_DQUOTE, 1'b0);         // legal escape
		put_byte(CH_BACKSLASH, 1'b0);
		put_byte(8'h71, 1'b0);             // illegal escape
		put_byte(CH_RPAREN, 1'b0);         // paren underflow
		put_byte(CH_RBRACKET, 1'b0);       // bracket underflow
		put_byte(CH_LPAREN, 1'b0);
		put_byte(CH_SPACE, 1'b0);          // space inside a group joins the token
		put_byte(CH_LBRACKET, 1'b0);
		put_byte(CH_TAB, 1'b0);
		put_byte(CH_CR, 1'b0);             // line end with groups still open
		put_byte(CH_LF, 1'b0);             // LF of the CR LF pair is dropped
		put_byte(CH_RPAREN, 1'b0);
		put_byte(CH_RBRACKET, 1'b0);
		put_byte(CH_DQUOTE, 1'b0);
		put_byte(CH_LF, 1'b0);             // newline inside quotes is just text
		put_byte(CH_HASH, 1'b0);           // so is a hash
		put_byte(CH_DQUOTE, 1'b0);
		put_byte(CH_HASH, 1'b0);           // comment flushes token and line
		put_byte(8'hFF, 1'b0);             // dropped inside the comment
		put_byte(CH_LF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(CH_TAB, 1'b0);
		put_byte(8'h80, 1'b1);             // buffer end flushes everything

		add_random_text(350);
		add_deep_group(CH_LPAREN, CH_RPAREN);
		add_deep_group(CH_LBRACKET, CH_RBRACKET);
		add_random_text(350);
	endtask

	// Sender: bursts of back-to-back words with random gaps; hold the word while stalled
	initial begin
		int idx;
		int burst;
		int gap;
		build_text();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		idx = 0;
		while (idx < text_stream.size()) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && idx < text_stream.size()) begin
				src_valid <= 1'b1;
				src_word  <= text_stream[idx];
				do @(posedge clk); while (src_stall);
				idx++;
				burst--;
				words_sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				src_valid <= 1'b0;
				src_word  <= clt_in_t'(9'($urandom));
				repeat (gap) @(posedge clk);
			end
		end
		if (src_valid) begin
			src_valid <= 1'b0;
		end

		// wait so the last accepted word shows up in the count of words due
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Receiver: stall in stretches of differing density, with one long hold-off once
	// the stream is under way so the block fills and pushes back on the sender
	initial begin
		int mode;
		int run;
		logic held_off;
		held_off = 1'b0;
		forever begin
			if (!held_off && words_sent >= 300) begin
				dst_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				held_off = 1'b1;
			end
			mode = $urandom_range(0, 3);
			run  = $urandom_range(20, 200);
			repeat (run) begin
				case (mode)
					0: dst_stall <= 1'b0;
					1: dst_stall <= ($urandom_range(0, 3) == 0);
					2: dst_stall <= ($urandom_range(0, 3) != 0);
					default: dst_stall <= ~dst_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	// Hang detector: count edges at which no word moves on either channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule
